// ----- design/ihb_pkg.sv -----
`default_nettype none
package ihb_pkg;

  // fixed header field values, network order
  localparam logic [15:0] VerIhlTos = 16'h4500;
  localparam logic [15:0] IdentNet  = 16'h0001;
  localparam logic [15:0] FlagsDf   = 16'h4000;
  localparam logic [7:0]  TtlValue  = 8'h40;
  localparam logic [15:0] LenMax    = 16'hFFFF;
  localparam logic [16:0] HdrBytes  = 17'd20;

  // header is five words; index of the final one
  localparam int unsigned HdrWords = 5;
  localparam logic [2:0]  LastIdx  = 3'(HdrWords - 1);

  // depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // register indexes of the configuration port
  typedef enum logic [7:0] {
    CfgOwnAddr    = 8'd0,
    CfgSubnetMask = 8'd1,
    CfgGateway    = 8'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] own_address;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_address;
  } cfg_t;

  // one classified request, ready to be sent as five words
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] src;
    logic [7:0]  proto;
    logic [15:0] total;
    logic [15:0] csum;
    logic [31:0] hop;
    logic        lerr;
  } hdr_entry_t;

endpackage
`default_nettype wire

// ----- design/ihb_front.sv -----
`default_nettype none
module ihb_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        dest_address_i,
  input  wire logic [7:0]         protocol_number_i,
  input  wire logic [15:0]        payload_length_i,
  input  wire ihb_pkg::cfg_t      cfg_i,
  input  wire logic               full_i,
  output logic                    busy_o,
  output logic                    push_o,
  output ihb_pkg::hdr_entry_t     entry_o
);
  import ihb_pkg::*;

  logic        accept;
  logic [16:0] total_ext;
  logic        lerr_d;
  logic [15:0] total_d;
  logic [15:0] ttl_proto;
  logic [19:0] sum_d;
  logic [31:0] hop_d;
  logic [16:0] fold1;
  logic [15:0] fold2;

  logic        stage_valid_q, stage_valid_d;
  logic [31:0] dest_q, src_q, hop_q;
  logic [7:0]  proto_q;
  logic [15:0] total_q;
  logic [19:0] sum_q;
  logic        lerr_q;

  assign push_o = stage_valid_q && !full_i;
  assign busy_o = stage_valid_q && full_i;
  assign accept = start_i && !busy_o;
  assign stage_valid_d = accept || (stage_valid_q && !push_o);

  // total length with saturation
  assign total_ext = {1'b0, payload_length_i} + HdrBytes;
  assign lerr_d    = total_ext[16];
  assign total_d   = lerr_d ? LenMax : total_ext[15:0];
  assign ttl_proto = {TtlValue, protocol_number_i};

  // raw sum of the nine nonzero halfwords, fits in 20 bits
  assign sum_d = 20'(VerIhlTos) + 20'(total_d) + 20'(IdentNet) + 20'(FlagsDf)
               + 20'(ttl_proto)
               + 20'(cfg_i.own_address[31:16]) + 20'(cfg_i.own_address[15:0])
               + 20'(dest_address_i[31:16]) + 20'(dest_address_i[15:0]);

  assign hop_d = ((dest_address_i & cfg_i.subnet_mask) ==
                  (cfg_i.own_address & cfg_i.subnet_mask))
                 ? dest_address_i : cfg_i.gateway_address;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dest_q  <= dest_address_i;
      src_q   <= cfg_i.own_address;
      proto_q <= protocol_number_i;
      total_q <= total_d;
      sum_q   <= sum_d;
      hop_q   <= hop_d;
      lerr_q  <= lerr_d;
    end
  end

  // two folds bring the sum to 16 bits; the second cannot carry again
  assign fold1 = {1'b0, sum_q[15:0]} + {13'd0, sum_q[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    entry_o.dest  = dest_q;
    entry_o.src   = src_q;
    entry_o.proto = proto_q;
    entry_o.total = total_q;
    entry_o.csum  = ~fold2;
    entry_o.hop   = hop_q;
    entry_o.lerr  = lerr_q;
  end

endmodule
`default_nettype wire

// ----- design/ihb_queue.sv -----
`default_nettype none
module ihb_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ihb_pkg::hdr_entry_t entry_i,
  input  wire logic                pop_i,
  output ihb_pkg::hdr_entry_t      entry_o,
  output logic                     full_o,
  output logic                     empty_o
);
  import ihb_pkg::*;

  localparam logic [QueuePtrW:0] DepthVal = (QueuePtrW + 1)'(QueueDepth);

  hdr_entry_t           slots_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q;

  assign full_o  = (count_q == DepthVal);
  assign empty_o = (count_q == '0);
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/ihb_back.sv -----
`default_nettype none
module ihb_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ihb_pkg::hdr_entry_t entry_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     result_valid_o,
  output logic [31:0]              header_word_o,
  output logic [2:0]               word_index_o,
  output logic                     last_word_o,
  output logic [31:0]              next_hop_o,
  output logic                     length_error_o
);
  import ihb_pkg::*;

  logic [2:0]  cnt_q;
  logic        valid_q;
  logic [31:0] word;
  logic [31:0] word_q, hop_q;
  logic [2:0]  idx_q;
  logic        last_q, lerr_q;

  assign pop_o = !empty_i && (cnt_q == LastIdx);

  always_comb begin
    case (cnt_q)
      3'd0:    word = {VerIhlTos, entry_i.total};
      3'd1:    word = {IdentNet, FlagsDf};
      3'd2:    word = {TtlValue, entry_i.proto, entry_i.csum};
      3'd3:    word = entry_i.src;
      default: word = entry_i.dest;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        cnt_q <= (cnt_q == LastIdx) ? '0 : cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!empty_i) begin
      word_q <= word;
      idx_q  <= cnt_q;
      last_q <= (cnt_q == LastIdx);
      hop_q  <= entry_i.hop;
      lerr_q <= entry_i.lerr;
    end
  end

  assign result_valid_o = valid_q;
  assign header_word_o  = word_q;
  assign word_index_o   = idx_q;
  assign last_word_o    = last_q;
  assign next_hop_o     = hop_q;
  assign length_error_o = lerr_q;

endmodule
`default_nettype wire

// ----- design/ipv4_header_builder.sv -----
`default_nettype none
// ipv4 header builder
// request channel: start_i with dest_address_i, protocol_number_i and
//   payload_length_i; a request is taken at a clock edge with start_i high
//   and busy_o low
// result channel: result_valid_o strobes one header word per cycle, five
//   words per request, word_index_o 0..4, last_word_o on the fifth; next_hop_o
//   and length_error_o are the same on all five words
// config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 own address, 1 subnet mask, 2 gateway; other indexes ignored;
//   cfg_ready_o is always high, write only while idle
// path: front stage register, queue, then back-end output register; a full
//   queue holds a request in the front stage; the back end sends one 32-bit
//   word per cycle, and a front stage plus a two-entry queue let requests be
//   taken while earlier headers are still going out
// the receiver cannot stall; results are never held off
// reset: control and config registers clear to zero, queue empties, no result pending
module ipv4_header_builder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [31:0] dest_address_i,
  input  wire logic [7:0]  protocol_number_i,
  input  wire logic [15:0] payload_length_i,
  // config channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // result channel
  output logic             result_valid_o,
  output logic [31:0]      header_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o,
  output logic [31:0]      next_hop_o,
  output logic             length_error_o
);
  import ihb_pkg::*;

  cfg_t       cfg_q;
  hdr_entry_t front_entry;
  hdr_entry_t queue_entry;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  // config registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgOwnAddr:    cfg_q.own_address     <= cfg_data_i;
        CfgSubnetMask: cfg_q.subnet_mask     <= cfg_data_i;
        CfgGateway:    cfg_q.gateway_address <= cfg_data_i;
        default:       ;  // unknown index, write dropped
      endcase
    end
  end

  // front: takes requests, works out length, checksum and next hop
  ihb_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .dest_address_i    (dest_address_i),
    .protocol_number_i (protocol_number_i),
    .payload_length_i  (payload_length_i),
    .cfg_i             (cfg_q),
    .full_i            (full),
    .busy_o            (busy_o),
    .push_o            (push),
    .entry_o           (front_entry)
  );

  // short queue decoupling classification from word output
  ihb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .pop_i   (pop),
    .entry_o (queue_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: sends the five header words, one per cycle
  ihb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (queue_entry),
    .empty_i        (empty),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .header_word_o  (header_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o),
    .next_hop_o     (next_hop_o),
    .length_error_o (length_error_o)
  );

  // a header's words go out in unbroken order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_word_o |=>
      result_valid_o && (word_index_o == $past(word_index_o) + 3'd1))
    else $error("header words not consecutive");

  // last word flag marks the fifth word only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_word_o == (word_index_o == LastIdx)))
    else $error("last word flag out of place");

  // a burst of words always starts at the first header word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> (word_index_o == 3'd0))
    else $error("header burst starts mid header");

  // queue never overflows or underflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full && !pop) && !(pop && empty))
    else $error("queue overflow or underflow");

endmodule
`default_nettype wire
